// File: rtl/core/amt_pkg.sv
// ----------------------------------------------------------------------------
// amt_pkg
// Shared constants, payload structs and control types for the aging mapping
// table.
// ----------------------------------------------------------------------------
package amt_pkg;

    localparam int NUM_ENTRIES = 16;
    localparam int AGE_BITS    = 16;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);
    localparam int SLOT_W      = 4;

    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_FLUSH  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] key;
        logic [31:0] buf_size;
        logic [31:0] new_base;
    } amt_req_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       base_out;
        logic              evicted;
        logic [31:0]       evicted_key;
        logic [31:0]       evicted_base;
        logic [31:0]       evicted_size;
    } amt_rsp_t;

    // Search token walking down the cell chain.
    typedef struct packed {
        logic [31:0]         key;
        logic                hit;
        logic [IDX_W-1:0]    sel_slot;
        logic [AGE_BITS-1:0] sel_age;
        logic                sel_valid;
        logic [31:0]         sel_key;
        logic [31:0]         sel_base;
        logic [31:0]         sel_size;
    } amt_token_t;

    // Broadcast write to every cell: install one entry or flush all.
    typedef struct packed {
        logic             install;
        logic             flush;
        logic [IDX_W-1:0] slot;
        logic [31:0]      key;
        logic [31:0]      size;
        logic [31:0]      base;
    } amt_wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } amt_state_t;

endpackage

// File: rtl/core/amt_cell.sv
// ----------------------------------------------------------------------------
// amt_cell
// One table entry: compares the passing token's key, ages itself and updates
// the token's oldest-entry candidate before handing it to the next cell.
// ----------------------------------------------------------------------------
module amt_cell
    import amt_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] cell_idx,
    input  logic             tok_live_in,
    input  amt_token_t       tok_in,
    input  amt_wr_t          wr,
    output logic             tok_live_out,
    output amt_token_t       tok_out
);

    logic                valid_reg, valid_next;
    logic [AGE_BITS-1:0] age_reg, age_next;
    logic [31:0]         key_reg, key_next;
    logic [31:0]         size_reg, size_next;
    logic [31:0]         base_reg, base_next;
    logic                live_reg;
    amt_token_t          tok_reg, tok_next;

    logic                match;
    logic                wr_here;
    logic [AGE_BITS-1:0] age_inc;

    assign match   = valid_reg && (key_reg == tok_in.key);
    assign wr_here = wr.install && (wr.slot == cell_idx);
    assign age_inc = (age_reg == AGE_MAX) ? age_reg : age_reg + 1'b1;

    always_comb begin
        tok_next = tok_in;
        if (match && !tok_in.hit) begin
            tok_next.hit      = 1'b1;
            tok_next.sel_slot = cell_idx;
            tok_next.sel_base = base_reg;
        end else if (!tok_in.hit && !match && (age_inc > tok_in.sel_age)) begin
            // strict compare keeps the lowest index on ties
            tok_next.sel_slot  = cell_idx;
            tok_next.sel_age   = age_inc;
            tok_next.sel_valid = valid_reg;
            tok_next.sel_key   = key_reg;
            tok_next.sel_base  = base_reg;
            tok_next.sel_size  = size_reg;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        age_next   = age_reg;
        key_next   = key_reg;
        size_next  = size_reg;
        base_next  = base_reg;
        priority if (wr.flush) begin
            valid_next = 1'b0;
        end else if (wr_here) begin
            valid_next = 1'b1;
            age_next   = '0;
            key_next   = wr.key;
            size_next  = wr.size;
            base_next  = wr.base;
        end else if (tok_live_in) begin
            age_next = match ? '0 : age_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
            live_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            age_reg   <= age_next;
            live_reg  <= tok_live_in;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        size_reg <= size_next;
        base_reg <= base_next;
        if (tok_live_in) begin
            tok_reg <= tok_next;
        end
    end

    assign tok_live_out = live_reg;
    assign tok_out      = tok_reg;

endmodule

// File: rtl/core/aging_mapping_table_unit.sv
// ----------------------------------------------------------------------------
// aging_mapping_table_unit
// Fully associative buffer mapping table with age-based replacement.
// ----------------------------------------------------------------------------
// Items are handled one at a time. A lookup passes its search token down the
// row of entry cells one cell per clock, then a finish step installs on a
// miss and loads the result register. A flush goes straight to the finish
// step. The result sits in an output register, so the next item is taken
// while an earlier result still waits for its transfer; a finished search
// holds at the end of the row until that register is free.
module aging_mapping_table_unit
    import amt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  amt_req_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output amt_rsp_t m_data
);

    amt_state_t state_reg, state_next;
    amt_req_t   req_reg;
    logic       start_reg;
    logic       m_valid_reg;
    amt_rsp_t   rsp_reg, rsp_next;

    logic       in_xfer;
    logic       out_free;
    logic       fin_go;
    amt_token_t init_tok;
    amt_token_t end_tok;
    amt_wr_t    wr;

    logic       chain_live [NUM_ENTRIES];
    amt_token_t chain_tok  [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] live_vec;

    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign end_tok  = chain_tok[NUM_ENTRIES-1];

    always_comb begin
        init_tok           = '0;
        init_tok.key       = req_reg.key;
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_ENTRIES; gi++) begin : g_cell
            assign live_vec[gi] = chain_live[gi];
            if (gi == 0) begin : g_head
                amt_cell u_cell (
                    .aclk         (aclk),
                    .aresetn      (aresetn),
                    .cell_idx     (IDX_W'(gi)),
                    .tok_live_in  (start_reg),
                    .tok_in       (init_tok),
                    .wr           (wr),
                    .tok_live_out (chain_live[gi]),
                    .tok_out      (chain_tok[gi])
                );
            end else begin : g_body
                amt_cell u_cell (
                    .aclk         (aclk),
                    .aresetn      (aresetn),
                    .cell_idx     (IDX_W'(gi)),
                    .tok_live_in  (chain_live[gi-1]),
                    .tok_in       (chain_tok[gi-1]),
                    .wr           (wr),
                    .tok_live_out (chain_live[gi]),
                    .tok_out      (chain_tok[gi])
                );
            end
        end
    endgenerate

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_data.action == ACT_FLUSH) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (chain_live[NUM_ENTRIES-1]) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready = 1'b0;
        fin_go  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_ready = 1'b1;
            ST_SCAN:   s_ready = 1'b0;
            ST_FINISH: fin_go  = out_free;
            default:   s_ready = 1'b0;
        endcase
    end

    always_comb begin
        rsp_next   = '0;
        wr         = '0;
        wr.slot    = end_tok.sel_slot;
        wr.key     = req_reg.key;
        wr.size    = req_reg.buf_size;
        wr.base    = req_reg.new_base;
        if (req_reg.action == ACT_FLUSH) begin
            wr.flush = fin_go;
        end else if (end_tok.hit) begin
            rsp_next.hit      = 1'b1;
            rsp_next.slot     = SLOT_W'(end_tok.sel_slot);
            rsp_next.base_out = end_tok.sel_base;
        end else begin
            wr.install        = fin_go;
            rsp_next.slot     = SLOT_W'(end_tok.sel_slot);
            rsp_next.base_out = req_reg.new_base;
            if (end_tok.sel_valid) begin
                rsp_next.evicted      = 1'b1;
                rsp_next.evicted_key  = end_tok.sel_key;
                rsp_next.evicted_base = end_tok.sel_base;
                rsp_next.evicted_size = end_tok.sel_size;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= in_xfer && (s_data.action == ACT_LOOKUP);
            if (fin_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            req_reg <= s_data;
        end
        if (fin_go) begin
            rsp_reg <= rsp_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

    // at most one search token in flight
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({start_reg, live_vec}))
        else $error("more than one search token in the cell row");

    // the row is empty whenever a new item can be taken
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!start_reg && (live_vec == '0)))
        else $error("search token alive while idle");

    // a new result only comes out of the finish step
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid && !m_ready)) |-> $past(state_reg == ST_FINISH))
        else $error("result loaded outside the finish step");

    // a hit never reports an eviction
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.hit) |-> !m_data.evicted)
        else $error("hit result carries an eviction");

endmodule

// File: bench/aging_mapping_table_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aging_mapping_table_unit_tb
// Drives lookups, installs and flushes into the mapping table over the
// valid/ready channels and checks every result transfer, in order, against a
// cycle-free model of the table: key match on valid entries, saturating
// aging, first-oldest replacement and eviction reports.
// ----------------------------------------------------------------------------
import amt_pkg::*;

class amt_scoreboard;
    logic                vld   [NUM_ENTRIES];
    logic [31:0]         keys  [NUM_ENTRIES];
    logic [31:0]         sizes [NUM_ENTRIES];
    logic [31:0]         bases [NUM_ENTRIES];
    logic [AGE_BITS-1:0] ages  [NUM_ENTRIES];
    amt_rsp_t            expected_q[$];
    int errors;
    int n_hit;
    int n_install;
    int n_evict;
    int n_flush;
    int n_checked;

    function new();
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            vld[i]   = 1'b0;
            keys[i]  = '0;
            sizes[i] = '0;
            bases[i] = '0;
            ages[i]  = '0;
        end
        errors    = 0;
        n_hit     = 0;
        n_install = 0;
        n_evict   = 0;
        n_flush   = 0;
        n_checked = 0;
    endfunction

    // Update the table for one accepted request and queue its result.
    function void note_request(amt_req_t req);
        amt_rsp_t            rsp;
        logic                found;
        int                  victim;
        logic [AGE_BITS-1:0] oldest;
        rsp    = '0;
        found  = 1'b0;
        victim = 0;
        oldest = '0;
        if (req.action == ACT_FLUSH) begin
            for (int i = 0; i < NUM_ENTRIES; i++) vld[i] = 1'b0;
            n_flush++;
            expected_q.push_back(rsp);
            return;
        end
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (vld[i] && keys[i] == req.key) begin
                if (!found) begin
                    rsp.slot     = i[SLOT_W-1:0];
                    rsp.base_out = bases[i];
                end
                found   = 1'b1;
                ages[i] = '0;
            end else begin
                if (ages[i] != AGE_MAX) ages[i]++;
                // strict compare keeps the lowest index on ties
                if (ages[i] > oldest) begin
                    oldest = ages[i];
                    victim = i;
                end
            end
        end
        if (found) begin
            rsp.hit = 1'b1;
            n_hit++;
        end else begin
            if (vld[victim]) begin
                rsp.evicted      = 1'b1;
                rsp.evicted_key  = keys[victim];
                rsp.evicted_base = bases[victim];
                rsp.evicted_size = sizes[victim];
                n_evict++;
            end
            vld[victim]   = 1'b1;
            keys[victim]  = req.key;
            sizes[victim] = req.buf_size;
            bases[victim] = req.new_base;
            ages[victim]  = '0;
            rsp.slot      = victim[SLOT_W-1:0];
            rsp.base_out  = req.new_base;
            n_install++;
        end
        expected_q.push_back(rsp);
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    function void check_response(amt_rsp_t got);
        amt_rsp_t exp_r;
        if (expected_q.size() == 0) begin
            $error("result transfer with nothing expected: %h", got);
            errors++;
            return;
        end
        exp_r = expected_q.pop_front();
        n_checked++;
        cmp("hit",          32'(exp_r.hit),     32'(got.hit));
        cmp("slot",         32'(exp_r.slot),    32'(got.slot));
        cmp("base_out",     exp_r.base_out,     got.base_out);
        cmp("evicted",      32'(exp_r.evicted), 32'(got.evicted));
        cmp("evicted_key",  exp_r.evicted_key,  got.evicted_key);
        cmp("evicted_base", exp_r.evicted_base, got.evicted_base);
        cmp("evicted_size", exp_r.evicted_size, got.evicted_size);
    endfunction
endclass

module aging_mapping_table_unit_tb;

    localparam int NUM_RANDOM  = 1800;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 2 * NUM_ENTRIES + 8;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    amt_req_t s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    amt_rsp_t m_data;

    amt_scoreboard sb = new();

    bit no_idle  = 1'b0;
    bit hold_req = 1'b0;
    int hold_cnt = 0;

    logic [31:0] key_pool[32];
    int          pool_n;

    aging_mapping_table_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: random back-pressure, or a long counted hold when requested.
    always @(posedge aclk) begin
        if (hold_req) begin
            m_ready <= 1'b0;
            hold_cnt++;
            if (hold_cnt >= HOLD_CYCLES) begin
                hold_req = 1'b0;
                hold_cnt = 0;
            end
        end else begin
            m_ready <= no_idle || ($urandom_range(0, 99) >= 36);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_response(m_data);
    end

    function automatic amt_req_t mk(logic act, logic [31:0] k, logic [31:0] sz,
                                    logic [31:0] b);
        amt_req_t r;
        r.action   = act;
        r.key      = k;
        r.buf_size = sz;
        r.new_base = b;
        return r;
    endfunction

    // Valid stays high after the transfer; it is lowered only for a random gap or by the caller.
    task automatic send_item(input amt_req_t req);
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req);
        if (!no_idle && $urandom_range(0, 99) < 36) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        while (sb.expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic refill_pool();
        pool_n = $urandom_range(6, 32);
        foreach (key_pool[i]) key_pool[i] = $urandom;
    endtask

    initial begin
        amt_req_t req;
        int       roll;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty table: every age equal, entry 0 taken; then hit on it.
        send_item(mk(ACT_LOOKUP, 32'h0, 32'h0, 32'h0));
        send_item(mk(ACT_LOOKUP, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(mk(ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(mk(ACT_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // Stale keys must miss after a flush.
        send_item(mk(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8765_4321));
        send_item(mk(ACT_LOOKUP, 32'h0, 32'hA5A5_A5A5, 32'h5A5A_5A5A));
        // Fill past capacity so the oldest entries get evicted.
        for (int i = 0; i < 16; i++)
            send_item(mk(ACT_LOOKUP, 32'hC000_0000 + i, 32'h100 * (i + 1),
                         32'h8000_0000 | (i << 12)));
        send_item(mk(ACT_LOOKUP, 32'hC000_0003, 32'h0, 32'h0));
        send_item(mk(ACT_LOOKUP, 32'hC000_000F, 32'h0, 32'h0));
        send_item(mk(ACT_LOOKUP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001));
        send_item(mk(ACT_FLUSH, 32'h0, 32'h0, 32'h0));

        refill_pool();
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % 200 == 199) refill_pool();
            if (n == 500) no_idle = 1'b1;
            if (n == 800) no_idle = 1'b0;
            if (n == 1000) hold_req = 1'b1;
            if (n == 1400) begin
                // sender goes quiet until every result is back
                s_valid <= 1'b0;
                wait_drained();
            end
            roll = $urandom_range(0, 99);
            req.action   = (roll < 3) ? ACT_FLUSH : ACT_LOOKUP;
            req.key      = (roll < 13) ? $urandom : key_pool[$urandom_range(0, pool_n - 1)];
            req.buf_size = $urandom;
            req.new_base = $urandom;
            send_item(req);
        end
        s_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("checked %0d results: %0d hits, %0d installs, %0d evictions, %0d flushes",
                 sb.n_checked, sb.n_hit, sb.n_install, sb.n_evict, sb.n_flush);
        $display("stimulus included a %0d-cycle receiver hold and a full drain pause",
                 HOLD_CYCLES);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("aging_mapping_table_unit_tb: PASS");
        end else begin
            $display("aging_mapping_table_unit_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", sb.expected_q.size());
        $display("aging_mapping_table_unit_tb: FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/amt_pkg.sv
rtl/core/amt_cell.sv
rtl/core/aging_mapping_table_unit.sv
bench/aging_mapping_table_unit_tb.sv
